/* rtl/mvd_pkg.sv */
// mvd_pkg: shared types and constants for the masked vector distance block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mvd_pkg;

   // field widths
   localparam int VAL_W    = 16;
   localparam int DIST_W   = 48;
   localparam int PAIRS_W  = 13;
   localparam int MAIN_W   = 48;
   localparam int CROSS_W  = 44;
   localparam int SQ_W     = 43;
   localparam int NUM_W    = 64;
   localparam int DVS_W    = 48;
   localparam int ROOT_W   = 32;
   localparam int STEP_W   = 7;
   localparam int PADDR_W  = 3;

   localparam int VECTOR_MAX_DEF = 4096;

   // one in Q.16
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // register index of the metric register
   localparam logic REG_METRIC = 1'b0;

   typedef enum logic [1:0] {
      MET_CHORD = 2'd0,
      MET_CANB  = 2'd1,
      MET_MAN   = 2'd2,
      MET_EUC   = 2'd3
   } metric_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MUL,
      OP_ACC,
      OP_CANB_DIV,
      OP_CANB_ADD,
      OP_FIN_DIV,
      OP_NA_SQRT,
      OP_NB_SQRT,
      OP_PROD,
      OP_CHORD_DIV,
      OP_T_SQRT,
      OP_EUC_SQRT,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      RES_UNDEF,
      RES_MAN,
      RES_DIV,
      RES_ROOT
   } res_sel_type;

   typedef struct packed {
      dp_op_type   op;
      res_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      metric_type metric;
      logic       counts;
      logic       last;
      logic       count_zero;
      logic       div_busy;
      logic       sqrt_busy;
      logic       d_zero;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/mvd_divider.sv */
// mvd_divider: restoring divider, one quotient bit per cycle
// uses mvd_pkg; numerator is loaded left aligned, quotient ends in the low bits
`timescale 1ns / 1ps
`default_nettype none

module mvd_divider
   import mvd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [DVS_W-1:0]  divisor,
   input  wire logic [STEP_W-1:0] steps,
   output logic                   busy,
   output logic [NUM_W-1:0]       quotient
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = numer;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

/* rtl/mvd_isqrt.sv */
// mvd_isqrt: floor square root, one root bit per cycle
// uses mvd_pkg; 64-bit radicand, 32-bit root
`timescale 1ns / 1ps
`default_nettype none

module mvd_isqrt
   import mvd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] radicand,
   output logic                  busy,
   output logic [ROOT_W-1:0]     root
);

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  shifted;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;
   logic              ge;

   // bring down two radicand bits and try root*4+1
   always_comb begin
      shifted = {rem_ff, rad_ff[NUM_W-1:NUM_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      ge      = (shifted >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         rad_in  = {rad_ff[NUM_W-3:0], 2'b00};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

/* rtl/mvd_datapath.sv */
// mvd_datapath: element capture, products, saturating sums, divider, root and result beat
// uses mvd_pkg, mvd_divider and mvd_isqrt; driven by mvd_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module mvd_datapath
   import mvd_pkg::*;
#(
   parameter int VECTOR_MAX = VECTOR_MAX_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire metric_type        metric,
   input  wire dp_cmd_type        cmd,
   output dp_status_type          status,
   input  wire logic [VAL_W-1:0]  req_first_value,
   input  wire logic [VAL_W-1:0]  req_second_value,
   input  wire logic              req_first_missing,
   input  wire logic              req_second_missing,
   input  wire logic              req_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DIST_W-1:0]      rsp_distance,
   output logic                   rsp_undefined,
   output logic [PAIRS_W-1:0]     rsp_pairs_used
);

   localparam int CNT_W = $clog2(VECTOR_MAX + 1);

   // captured element pair
   logic signed [VAL_W-1:0] a_ff, b_ff;
   logic                    miss_ff, last_ff;

   // products stage
   logic signed [2*VAL_W-1:0] prod_ab_ff;
   logic [2*VAL_W-1:0]        sq1_ff, sqb_ff;
   logic [VAL_W-1:0]          adiff_ff;
   logic [VAL_W:0]            den_ff;

   // accumulators
   logic [MAIN_W-1:0]         main_ff, main_in;
   logic signed [CROSS_W-1:0] cross_ff, cross_in;
   logic [SQ_W-1:0]           sqa_sum_ff, sqa_sum_in;
   logic [SQ_W-1:0]           sqb_sum_ff, sqb_sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // chord finish
   logic [ROOT_W-1:0]   na_ff;
   logic [NUM_W-1:0]    dprod_ff;

   // result beat
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic                undef_ff;
   logic [PAIRS_W-1:0]  pairs_ff;

   logic [VAL_W-1:0]     abs_a, abs_b, mul_in;
   logic signed [VAL_W:0] diff17;
   logic [VAL_W-1:0]     adiff;
   logic                 take, counts;
   logic signed [CROSS_W:0] cross_sum;
   logic [SQ_W:0]        sqa_sum, sqb_sum;
   logic [CROSS_W-1:0]   mag;
   logic [CROSS_W-1:0]   dval;
   logic [16:0]          ratio;
   logic [18:0]          tval;
   logic [31:0]          cnt_wide;
   logic [DIST_W-1:0]    man_dist;

   logic                 div_start, div_busy;
   logic [NUM_W-1:0]     div_numer, quotient;
   logic [DVS_W-1:0]     div_dvs;
   logic [STEP_W-1:0]    div_steps;
   logic                 sqrt_start, sqrt_busy;
   logic [NUM_W-1:0]     radicand;
   logic [ROOT_W-1:0]    root;

   function automatic logic [MAIN_W-1:0] sat_main(input logic [MAIN_W-1:0] acc,
                                                 input logic [MAIN_W-1:0] add);
      logic [MAIN_W:0] sum;
      sum = {1'b0, acc} + {1'b0, add};
      return sum[MAIN_W] ? {MAIN_W{1'b1}} : sum[MAIN_W-1:0];
   endfunction

   // element magnitudes and difference
   always_comb begin
      abs_a  = a_ff[VAL_W-1] ? VAL_W'(-a_ff) : VAL_W'(a_ff);
      abs_b  = b_ff[VAL_W-1] ? VAL_W'(-b_ff) : VAL_W'(b_ff);
      diff17 = (VAL_W+1)'(a_ff) - (VAL_W+1)'(b_ff);
      adiff  = diff17[VAL_W] ? VAL_W'(-diff17) : diff17[VAL_W-1:0];
      mul_in = (metric == MET_EUC) ? adiff : abs_a;
   end

   // pair is counted unless missing, full, or a zero canberra denominator
   always_comb begin
      take   = !miss_ff && (count_ff < CNT_W'(VECTOR_MAX));
      counts = take && !((metric == MET_CANB) && (den_ff == '0));
   end

   // saturating sums for the chord pair
   always_comb begin
      cross_sum = (CROSS_W+1)'(cross_ff) + (CROSS_W+1)'(prod_ab_ff);
      sqa_sum   = {1'b0, sqa_sum_ff} + (SQ_W+1)'(sq1_ff);
      sqb_sum   = {1'b0, sqb_sum_ff} + (SQ_W+1)'(sqb_ff);
   end

   // chord ratio and angle term
   always_comb begin
      mag   = cross_ff[CROSS_W-1] ? CROSS_W'(-cross_ff) : CROSS_W'(cross_ff);
      dval  = dprod_ff[NUM_W-1:20];
      ratio = (quotient > NUM_W'(ONE_Q16)) ? ONE_Q16 : quotient[16:0];
      if (cross_ff[CROSS_W-1]) begin
         tval = {({1'b0, ONE_Q16} + {1'b0, ratio}), 1'b0};
      end else begin
         tval = {({1'b0, ONE_Q16} - {1'b0, ratio}), 1'b0};
      end
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_dvs   = '0;
      div_steps = '0;
      case (cmd.op)
         OP_CANB_DIV: begin
            div_start = 1'b1;
            div_numer = {adiff_ff, 16'h0000, 32'h0};
            div_dvs   = DVS_W'(den_ff);
            div_steps = STEP_W'(32);
         end
         OP_FIN_DIV: begin
            div_start = 1'b1;
            div_numer = {main_ff, 16'h0000};
            div_dvs   = DVS_W'(count_ff);
            div_steps = STEP_W'(MAIN_W);
         end
         OP_CHORD_DIV: begin
            div_start = 1'b1;
            div_numer = {4'h0, mag, 16'h0000};
            div_dvs   = DVS_W'(dval);
            div_steps = STEP_W'(NUM_W);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // root operand select
   always_comb begin
      sqrt_start = 1'b1;
      radicand   = '0;
      case (cmd.op)
         OP_NA_SQRT:  radicand = {1'b0, sqa_sum_ff, 20'h00000};
         OP_NB_SQRT:  radicand = {1'b0, sqb_sum_ff, 20'h00000};
         OP_T_SQRT:   radicand = NUM_W'({tval, 16'h0000});
         OP_EUC_SQRT: radicand = {main_ff, 16'h0000};
         default:     sqrt_start = 1'b0;
      endcase
   end

   mvd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (quotient)
   );

   mvd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // accumulator updates
   always_comb begin
      main_in    = main_ff;
      cross_in   = cross_ff;
      sqa_sum_in = sqa_sum_ff;
      sqb_sum_in = sqb_sum_ff;
      count_in   = count_ff;
      case (cmd.op)
         OP_ACC: begin
            if (counts) begin
               count_in = count_ff + CNT_W'(1);
               case (metric)
                  MET_CHORD: begin
                     if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
                        cross_in = cross_sum[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                                      : {1'b0, {(CROSS_W-1){1'b1}}};
                     end else begin
                        cross_in = cross_sum[CROSS_W-1:0];
                     end
                     sqa_sum_in = sqa_sum[SQ_W] ? {SQ_W{1'b1}} : sqa_sum[SQ_W-1:0];
                     sqb_sum_in = sqb_sum[SQ_W] ? {SQ_W{1'b1}} : sqb_sum[SQ_W-1:0];
                  end
                  MET_MAN: main_in = sat_main(main_ff, MAIN_W'(adiff_ff));
                  MET_EUC: main_in = sat_main(main_ff, MAIN_W'(sq1_ff));
                  default: main_in = main_ff;
               endcase
            end
         end
         OP_CANB_ADD: begin
            main_in  = sat_main(main_ff, quotient[MAIN_W-1:0]);
            count_in = count_ff + CNT_W'(1);
         end
         OP_EMIT: begin
            main_in    = '0;
            cross_in   = '0;
            sqa_sum_in = '0;
            sqb_sum_in = '0;
            count_in   = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      cnt_wide = 32'(count_ff);
      man_dist = (main_ff[MAIN_W-1:MAIN_W-8] != 8'h00) ? {DIST_W{1'b1}}
                                                        : {main_ff[MAIN_W-9:0], 8'h00};
   end

   // capture and products
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         a_ff    <= req_first_value;
         b_ff    <= req_second_value;
         miss_ff <= req_first_missing | req_second_missing;
         last_ff <= req_last;
      end
      if (cmd.op == OP_MUL) begin
         prod_ab_ff <= a_ff * b_ff;
         sq1_ff     <= mul_in * mul_in;
         sqb_ff     <= abs_b * abs_b;
         adiff_ff   <= adiff;
         den_ff     <= {1'b0, abs_a} + {1'b0, abs_b};
      end
      if (cmd.op == OP_NB_SQRT) begin
         na_ff <= root;
      end
      if (cmd.op == OP_PROD) begin
         dprod_ff <= NUM_W'(na_ff) * NUM_W'(root);
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff    <= '0;
         cross_ff   <= '0;
         sqa_sum_ff <= '0;
         sqb_sum_ff <= '0;
         count_ff   <= '0;
      end else begin
         main_ff    <= main_in;
         cross_ff   <= cross_in;
         sqa_sum_ff <= sqa_sum_in;
         sqb_sum_ff <= sqb_sum_in;
         count_ff   <= count_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_EMIT) begin
         pairs_ff <= cnt_wide[PAIRS_W-1:0];
         undef_ff <= (cmd.sel == RES_UNDEF);
         case (cmd.sel)
            RES_MAN:  dist_ff <= man_dist;
            RES_DIV:  dist_ff <= quotient[DIST_W-1:0];
            RES_ROOT: dist_ff <= DIST_W'(root);
            default:  dist_ff <= '0;
         endcase
      end
   end

   always_comb begin
      status.metric     = metric;
      status.counts     = counts;
      status.last       = last_ff;
      status.count_zero = (count_ff == '0);
      status.div_busy   = div_busy;
      status.sqrt_busy  = sqrt_busy;
      status.d_zero     = (dval == '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_undefined  = undef_ff;
   assign rsp_pairs_used = pairs_ff;

endmodule

`default_nettype wire

/* rtl/mvd_ctrl.sv */
// mvd_ctrl: sequencer that steps one element pair and the final formula through the datapath
// uses mvd_pkg; talks to mvd_datapath only through dp_cmd_type and dp_status_type
`timescale 1ns / 1ps
`default_nettype none

module mvd_ctrl
   import mvd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'h0001,
      S_MUL   = 13'h0002,
      S_ACC   = 13'h0004,
      S_CWAIT = 13'h0008,
      S_FIN   = 13'h0010,
      S_NA    = 13'h0020,
      S_NB    = 13'h0040,
      S_DCHK  = 13'h0080,
      S_RDIV  = 13'h0100,
      S_TSQ   = 13'h0200,
      S_FDIV  = 13'h0400,
      S_ESQ   = 13'h0800,
      S_EMIT  = 13'h1000
   } state_type;

   state_type   state_ff, state_in;
   res_sel_type sel_ff, sel_in;

   // next state and command
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            if ((status.metric == MET_CANB) && status.counts) begin
               cmd.op   = OP_CANB_DIV;
               state_in = S_CWAIT;
            end else begin
               cmd.op   = OP_ACC;
               state_in = S_FIN;
            end
         end
         S_CWAIT: begin
            if (!status.div_busy) begin
               cmd.op   = OP_CANB_ADD;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.count_zero) begin
               sel_in   = RES_UNDEF;
               state_in = S_EMIT;
            end else begin
               unique case (status.metric)
                  MET_CHORD: begin
                     cmd.op   = OP_NA_SQRT;
                     state_in = S_NA;
                  end
                  MET_CANB: begin
                     cmd.op   = OP_FIN_DIV;
                     state_in = S_FDIV;
                  end
                  MET_MAN: begin
                     sel_in   = RES_MAN;
                     state_in = S_EMIT;
                  end
                  default: begin
                     cmd.op   = OP_EUC_SQRT;
                     state_in = S_ESQ;
                  end
               endcase
            end
         end
         S_NA: begin
            if (!status.sqrt_busy) begin
               cmd.op   = OP_NB_SQRT;
               state_in = S_NB;
            end
         end
         S_NB: begin
            if (!status.sqrt_busy) begin
               cmd.op   = OP_PROD;
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (status.d_zero) begin
               sel_in   = RES_UNDEF;
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_CHORD_DIV;
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            if (!status.div_busy) begin
               cmd.op   = OP_T_SQRT;
               state_in = S_TSQ;
            end
         end
         S_TSQ, S_ESQ: begin
            if (!status.sqrt_busy) begin
               sel_in   = RES_ROOT;
               state_in = S_EMIT;
            end
         end
         S_FDIV: begin
            if (!status.div_busy) begin
               sel_in   = RES_DIV;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= RES_UNDEF;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

/* rtl/masked_vector_distance.sv */
// masked_vector_distance: top level, metric register, controller and datapath
// uses mvd_pkg, mvd_ctrl and mvd_datapath
//
//   channel   ports            beat
//   request   req_*            one element pair, last marks the end of the vectors
//   response  rsp_*            one distance per vector pair
//   config    psel..prdata     metric register at byte address 0
//
// an element pair steps through capture, multiply, accumulate and finish; a counted
// canberra pair also waits on the radix-2 divider. the final pair adds: manhattan
// nothing, euclidean the root unit, canberra mean the divider, chord two roots,
// one multiply, a 64-step divide and one more root, before the result beat.
// reset is synchronous and clears all sums; a stalled response beat waits in its
// register while the next vector pair is accumulated.
`timescale 1ns / 1ps
`default_nettype none

module masked_vector_distance
   import mvd_pkg::*;
#(
   parameter int VECTOR_MAX = VECTOR_MAX_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [VAL_W-1:0]   req_first_value,
   input  wire logic [VAL_W-1:0]   req_second_value,
   input  wire logic               req_first_missing,
   input  wire logic               req_second_missing,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [DIST_W-1:0]       rsp_distance,
   output logic                    rsp_undefined,
   output logic [PAIRS_W-1:0]      rsp_pairs_used,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   metric_type    metric_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_hit;

   // metric register write
   assign csr_hit = (paddr[PADDR_W-1] == REG_METRIC);

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= MET_CHORD;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         metric_ff <= metric_type'(pwdata[1:0]);
      end
   end

   assign prdata = csr_hit ? {30'h0, metric_ff} : 32'h0;
   assign pready = 1'b1;

   mvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mvd_datapath #(
      .VECTOR_MAX (VECTOR_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .metric             (metric_ff),
      .cmd                (cmd),
      .status             (status),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .req_first_missing  (req_first_missing),
      .req_second_missing (req_second_missing),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distance       (rsp_distance),
      .rsp_undefined      (rsp_undefined),
      .rsp_pairs_used     (rsp_pairs_used)
   );

   // an undefined result carries a zero distance
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined |-> rsp_distance == '0)
      else $error("undefined result with nonzero distance");

   // a defined result always has at least one counted pair
   a_defined_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_undefined && (VECTOR_MAX < 8192) |-> rsp_pairs_used != '0)
      else $error("defined result with no counted pairs");

   // divider and root unit are never busy at the same time
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.div_busy && status.sqrt_busy))
      else $error("divider and root unit overlap");

   // a result beat is only loaded while the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> status.out_free)
      else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
